/* hw/rtl/srb_pkg.sv */
`default_nettype none

package srb_pkg;

    typedef struct packed {
        logic [31:0] seq_num;
        logic [31:0] domain_in;
        logic [31:0] event_in;
        logic [15:0] payload_in;
    } in_word_t;

    typedef struct packed {
        logic [31:0] seq_out;
        logic [31:0] domain_out;
        logic [31:0] event_out;
        logic [15:0] payload_out;
        logic [1:0]  status;
        logic        last_of_run;
    } out_word_t;

    typedef enum logic [1:0] {
        STAT_RELEASED = 2'd0,
        STAT_HELD     = 2'd1,
        STAT_STALE    = 2'd2,
        STAT_BEYOND   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_DRAIN
    } fsm_t;

endpackage

`default_nettype wire

/* hw/rtl/srb_stream_if.sv */
`default_nettype none

interface srb_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sequence_reorder_buffer_top.sv */
// Sequence reorder buffer.
// ingress (srb_stream_if of srb_pkg::in_word_t) takes one notification word
// per handshake; egress (srb_stream_if of srb_pkg::out_word_t) gives the
// result words, each with a status and last_of_run on the final word.
// Words are released strictly in sequence order after the last released
// one; early words wait in a ring of WINDOW slots held in a synchronous
// RAM, stale or out-of-window words are echoed back as dropped.
// A word is captured into the input registers and then evaluated; its
// result is loaded into the output register once that register is free.
// A new word is taken only after evaluation ends; a drain then releases
// buffered words in turn, set by the single RAM read port, up to WINDOW - 1 words.
// ingress.ready is high only while no word is being worked on; the
// output register lets the next word be captured while a result waits.
// A stalled egress holds the current result and freezes the drain.
// Reset clears the slot valid bits at once and sets the last released
// sequence to zero, so sequence 1 is expected first; no clearing pass.
`default_nettype none

module sequence_reorder_buffer_top #(
    parameter int WINDOW      = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    srb_stream_if.sink   ingress,
    srb_stream_if.source egress
);

    localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int HB    = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int ENT_W = 64 + HB;
    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
    localparam logic [IW:0]   WIN_EXT  = (IW + 1)'(WINDOW);
    localparam logic [31:0]   WIN_SEQ  = 32'(WINDOW);

    srb_pkg::fsm_t state_reg, state_next;
    logic [31:0]       lr_reg, lr_next;
    logic [IW-1:0]     eidx_reg, eidx_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    srb_pkg::out_word_t out_word_reg, out_word_next;

    logic [31:0]   in_seq_reg, in_dom_reg, in_ev_reg;
    logic [HB-1:0] in_pay_reg;

    logic [ENT_W-1:0] mem [WINDOW];
    logic [ENT_W-1:0] rd_data_reg;

    logic          cap_en, out_load, wr_en, rd_en;
    logic [IW-1:0] wr_idx, rd_idx;

    logic [31:0]   exp_seq, seq_gap;
    logic          is_next, is_held, is_stale;
    logic [IW:0]   held_sum, held_mod;
    logic [IW-1:0] held_idx, rel_eidx, drn_eidx;
    logic          out_free;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i, input logic to_zero);
        if (to_zero || i == LAST_IDX)
            return '0;
        return i + 1'b1;
    endfunction

    assign exp_seq  = lr_reg + 32'd1;
    assign seq_gap  = in_seq_reg - exp_seq;
    assign is_next  = (seq_gap == 32'd0);
    assign is_held  = !is_next && (seq_gap < WIN_SEQ);
    assign is_stale = seq_gap[31];

    // early slot: offset from the expected index, or the raw sequence once it has wrapped
    assign held_sum = {1'b0, eidx_reg} + {1'b0, seq_gap[IW-1:0]};
    assign held_mod = (held_sum >= WIN_EXT) ? held_sum - WIN_EXT : held_sum;
    assign held_idx = (in_seq_reg >= exp_seq) ? held_mod[IW-1:0] : in_seq_reg[IW-1:0];

    assign rel_eidx = idx_inc(eidx_reg, in_seq_reg == 32'hFFFF_FFFF);
    assign drn_eidx = idx_inc(eidx_reg, lr_reg == 32'hFFFF_FFFE);

    assign out_free      = !out_valid_reg || egress.ready;
    assign ingress.ready = (state_reg == srb_pkg::FSM_IDLE);
    assign egress.valid  = out_valid_reg;
    assign egress.data   = out_word_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srb_pkg::FSM_IDLE:
            begin
                if (ingress.valid)
                    state_next = srb_pkg::FSM_EVAL;
            end
            srb_pkg::FSM_EVAL:
            begin
                if (out_free)
                    state_next = (is_next && valid_reg[rel_eidx]) ? srb_pkg::FSM_DRAIN
                                                                   : srb_pkg::FSM_IDLE;
            end
            srb_pkg::FSM_DRAIN:
            begin
                if (out_free)
                    state_next = valid_reg[drn_eidx] ? srb_pkg::FSM_DRAIN : srb_pkg::FSM_IDLE;
            end
            default:
                state_next = srb_pkg::FSM_IDLE;
        endcase
    end

    always_comb
    begin
        cap_en        = 1'b0;
        out_load      = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_idx        = held_idx;
        rd_idx        = rel_eidx;
        lr_next       = lr_reg;
        eidx_next     = eidx_reg;
        valid_next    = valid_reg;
        out_word_next = out_word_reg;
        case (state_reg)
            srb_pkg::FSM_IDLE:
            begin
                cap_en = ingress.valid;
            end
            srb_pkg::FSM_EVAL:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_word_next.seq_out     = in_seq_reg;
                    out_word_next.domain_out  = in_dom_reg;
                    out_word_next.event_out   = in_ev_reg;
                    out_word_next.payload_out = 16'(in_pay_reg);
                    out_word_next.last_of_run = 1'b1;
                    if (is_next)
                    begin
                        out_word_next.status      = srb_pkg::STAT_RELEASED;
                        lr_next                   = in_seq_reg;
                        eidx_next                 = rel_eidx;
                        rd_idx                    = rel_eidx;
                        rd_en                     = valid_reg[rel_eidx];
                        out_word_next.last_of_run = !valid_reg[rel_eidx];
                    end
                    else if (is_held)
                    begin
                        out_word_next.status = srb_pkg::STAT_HELD;
                        wr_en                = 1'b1;
                        valid_next[held_idx] = 1'b1;
                    end
                    else if (is_stale)
                        out_word_next.status = srb_pkg::STAT_STALE;
                    else
                        out_word_next.status = srb_pkg::STAT_BEYOND;
                end
            end
            srb_pkg::FSM_DRAIN:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_word_next.seq_out     = exp_seq;
                    out_word_next.domain_out  = rd_data_reg[ENT_W-1 -: 32];
                    out_word_next.event_out   = rd_data_reg[HB +: 32];
                    out_word_next.payload_out = 16'(rd_data_reg[HB-1:0]);
                    out_word_next.status      = srb_pkg::STAT_RELEASED;
                    lr_next                   = exp_seq;
                    eidx_next                 = drn_eidx;
                    rd_idx                    = drn_eidx;
                    rd_en                     = valid_reg[drn_eidx];
                    out_word_next.last_of_run = !valid_reg[drn_eidx];
                end
            end
            default:
            begin
                cap_en = 1'b0;
            end
        endcase
        if (rd_en)
            valid_next[rd_idx] = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
        else if (egress.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srb_pkg::FSM_IDLE;
            lr_reg        <= '0;
            eidx_reg      <= IW'(1);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lr_reg        <= lr_next;
            eidx_reg      <= eidx_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            in_seq_reg <= ingress.data.seq_num;
            in_dom_reg <= ingress.data.domain_in;
            in_ev_reg  <= ingress.data.event_in;
            in_pay_reg <= ingress.data.payload_in[HB-1:0];
        end
        if (out_load)
            out_word_reg <= out_word_next;
    end

    // slot RAM: domain, event, handle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= {in_dom_reg, in_ev_reg, in_pay_reg};
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 16;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    srb_stream_if #(.word_t(srb_pkg::in_word_t))  in_if ();
    srb_stream_if #(.word_t(srb_pkg::out_word_t)) out_if ();

    sequence_reorder_buffer_top #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (16)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (in_if),
        .egress  (out_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    srb_pkg::in_word_t  notif_q[$];
    srb_pkg::out_word_t release_q[$];

    int send_idle = 36;
    int recv_idle = 52;
    int issued    = 0;
    int taken     = 0;
    int errors    = 0;
    int stall_cnt = 0;
    bit in_fire   = 1'b0;

    // shadow of the ring and the release pointer
    logic [31:0] rel_seq;
    logic        slot_ok  [WINDOW];
    logic [31:0] slot_dom [WINDOW];
    logic [31:0] slot_ev  [WINDOW];
    logic [15:0] slot_pay [WINDOW];

    // next expected sequence as seen by the stimulus generator
    logic [31:0] gen_next;

    function automatic void step_reorder(srb_pkg::in_word_t w);
        logic [31:0]        seq_gap;
        logic [31:0]        nxt;
        logic [3:0]         idx;
        srb_pkg::out_word_t r;
        seq_gap       = w.seq_num - (rel_seq + 32'd1);
        r.seq_out     = w.seq_num;
        r.domain_out  = w.domain_in;
        r.event_out   = w.event_in;
        r.payload_out = w.payload_in;
        r.last_of_run = 1'b1;
        if (seq_gap == 32'd0)
        begin
            rel_seq       = w.seq_num;
            r.status      = srb_pkg::STAT_RELEASED;
            r.last_of_run = 1'b0;
            nxt           = rel_seq + 32'd1;
            idx           = nxt[3:0];
            while (slot_ok[idx])
            begin
                release_q.push_back(r);
                slot_ok[idx]  = 1'b0;
                rel_seq       = nxt;
                r.seq_out     = nxt;
                r.domain_out  = slot_dom[idx];
                r.event_out   = slot_ev[idx];
                r.payload_out = slot_pay[idx];
                nxt           = rel_seq + 32'd1;
                idx           = nxt[3:0];
            end
            r.last_of_run = 1'b1;
        end
        else if (seq_gap < WINDOW)
        begin
            idx           = w.seq_num[3:0];
            slot_ok[idx]  = 1'b1;
            slot_dom[idx] = w.domain_in;
            slot_ev[idx]  = w.event_in;
            slot_pay[idx] = w.payload_in;
            r.status      = srb_pkg::STAT_HELD;
        end
        else if (seq_gap[31])
            r.status = srb_pkg::STAT_STALE;
        else
            r.status = srb_pkg::STAT_BEYOND;
        release_q.push_back(r);
    endfunction

    function automatic void add_word(logic [31:0] s, logic [31:0] d, logic [31:0] e,
                                     logic [15:0] p);
        srb_pkg::in_word_t w;
        w.seq_num    = s;
        w.domain_in  = d;
        w.event_in   = e;
        w.payload_in = p;
        notif_q.push_back(w);
        issued++;
    endfunction

    function automatic void add_rand(logic [31:0] s);
        add_word(s, $urandom, $urandom, 16'($urandom));
    endfunction

    function automatic void add_noise();
        case ($urandom_range(2, 0))
            0:       add_rand(gen_next - 32'd1 - $urandom_range(40, 0));
            1:       add_rand(gen_next + 32'd32 + $urandom_range(32'h7FFF0000, 0));
            default: add_rand($urandom);
        endcase
    endfunction

    // one contiguous run of k sequences in shuffled or reversed order, with repeats and noise
    function automatic void add_run();
        int k;
        int offs [WINDOW];
        int j;
        int t;
        k = ($urandom_range(3, 0) == 0) ? $urandom_range(WINDOW, 9) : $urandom_range(6, 1);
        for (int i = 0; i < k; i++)
            offs[i] = i;
        if ($urandom_range(4, 0) == 0)
        begin
            for (int i = 0; i < k; i++)
                offs[i] = k - 1 - i;
        end
        else
        begin
            for (int i = k - 1; i > 0; i--)
            begin
                j       = $urandom_range(i, 0);
                t       = offs[i];
                offs[i] = offs[j];
                offs[j] = t;
            end
        end
        for (int i = 0; i < k; i++)
        begin
            add_rand(gen_next + offs[i]);
            if ($urandom_range(99, 0) < 15)
                add_rand(gen_next + offs[$urandom_range(i, 0)]);
            if ($urandom_range(99, 0) < 12)
                add_noise();
        end
        gen_next = gen_next + k;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(99, 0) >= recv_idle);
        if (!in_if.valid || in_fire)
        begin
            if (rst_n && notif_q.size() != 0 && $urandom_range(99, 0) >= send_idle)
            begin
                in_if.valid <= 1'b1;
                in_if.data  <= notif_q.pop_front();
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // monitor and watchdog
    srb_pkg::out_word_t got;
    srb_pkg::out_word_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = in_if.valid && in_if.ready;
            if (in_fire)
            begin
                step_reorder(in_if.data);
                taken++;
            end
            if (out_if.valid && out_if.ready)
            begin
                got = out_if.data;
                if (release_q.size() == 0)
                    report_mismatch("unexpected word seq", got.seq_out, 32'd0);
                else
                begin
                    want = release_q.pop_front();
                    if (got.seq_out !== want.seq_out)
                        report_mismatch("seq_out", got.seq_out, want.seq_out);
                    if (got.domain_out !== want.domain_out)
                        report_mismatch("domain_out", got.domain_out, want.domain_out);
                    if (got.event_out !== want.event_out)
                        report_mismatch("event_out", got.event_out, want.event_out);
                    if (got.payload_out !== want.payload_out)
                        report_mismatch("payload_out", 32'(got.payload_out),
                                        32'(want.payload_out));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(got.last_of_run),
                                        32'(want.last_of_run));
                end
            end
            if (in_fire || (out_if.valid && out_if.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        rel_seq      = 32'd0;
        for (int i = 0; i < WINDOW; i++)
        begin
            slot_ok[i]  = 1'b0;
            slot_dom[i] = 32'd0;
            slot_ev[i]  = 32'd0;
            slot_pay[i] = 16'd0;
        end

        // directed: window edges, stale and beyond across the half range, repeats, drains
        add_word(32'd1, 32'h0, 32'h0, 16'h0);
        add_word(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        add_word(32'hFFFFFFFF, 32'hA5A5A5A5, 32'h5A5A5A5A, 16'hA5A5);
        add_word(32'd17, 32'hFFFFFFFF, 32'h0, 16'hFFFF);
        add_word(32'd18, 32'h0, 32'hFFFFFFFF, 16'h0);
        add_word(32'h80000001, 32'h12345678, 32'h9ABCDEF0, 16'h1234);
        add_word(32'h80000002, 32'h0F0F0F0F, 32'hF0F0F0F0, 16'h0F0F);
        add_word(32'd5, 32'h11111111, 32'h22222222, 16'h3333);
        add_word(32'd5, 32'h44444444, 32'h55555555, 16'h6666);
        add_word(32'd3, 32'h77777777, 32'h88888888, 16'h9999);
        add_word(32'd2, 32'hAAAAAAAA, 32'hBBBBBBBB, 16'hCCCC);
        add_word(32'd4, 32'hDDDDDDDD, 32'hEEEEEEEE, 16'hFFFF);
        for (int s = 21; s >= 7; s--)
        begin
            if (s != 17)
                add_rand(s);
        end
        add_rand(32'd6);
        gen_next = 32'd22;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (issued < 95)
            add_run();
        while (notif_q.size() != 0)
            @(negedge clk);

        send_idle = 52;
        recv_idle = 36;
        while (issued < 180)
            add_run();
        while (notif_q.size() != 0)
            @(negedge clk);

        send_idle = 0;
        recv_idle = 0;
        while (issued < 265)
            add_run();

        while (notif_q.size() != 0 || taken != issued || release_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (errors == 0 && release_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
